// ===== sv/srfp_pkg.sv =====
// constants and field layout shared by the servo reply frame parser
package srfp_pkg;

  localparam int unsigned MaxParams   = 4;
  localparam int unsigned MinLength   = 3;
  localparam int unsigned HeaderBytes = 2;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 4;
  localparam int unsigned LenW        = $clog2(MinLength + MaxParams + 1);
  localparam int unsigned CountW      = 3;
  localparam int unsigned ParamIdxW   = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int unsigned OutDataW    = 56;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  // byte positions inside a frame, counted from the first sync byte
  localparam logic [PosW-1:0] PosId      = PosW'(HeaderBytes);
  localparam logic [PosW-1:0] PosLength  = PosW'(HeaderBytes + 1);
  localparam logic [PosW-1:0] PosCommand = PosW'(HeaderBytes + 2);
  localparam logic [PosW-1:0] PosParam0  = PosW'(HeaderBytes + 3);

  localparam logic [ByteW-1:0] LenMin = ByteW'(MinLength);
  localparam logic [ByteW-1:0] LenMax = ByteW'(MinLength + MaxParams);

  // register map, word index taken from paddr[2]
  localparam logic RegSyncByte = 1'b0;
  localparam logic [ByteW-1:0] SyncByteReset = 8'h55;

  // result status codes
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusBadSum = 1'b1;

endpackage

// ===== sv/servo_reply_frame_parser_core.sv =====
// servo reply frame parser: sync hunt, length check, checksum and result register
//
// Usage: received bus bytes enter on the s_axis stream, one byte per transaction.
// The parser hunts for two sync bytes in a row (value set by the sync_byte register
// at address 0 of the APB port, reset 0x55), then takes id, length, command,
// length minus three parameter bytes and a checksum byte. A length outside 3..7
// drops the frame silently. Each finished frame yields one m_axis transaction:
// tuser carries the status (0 checksum ok, 1 mismatch), tdata the frame fields.
// Throughput is one byte per cycle while no waiting result stalls the input; the byte
// path is a single compare/add/store stage between the parser state registers and the
// result register. A result appears on m_axis in the cycle after its checksum byte is accepted.
// The result register doubles as the output stage: while a result waits and the
// receiver holds m_axis_tready_i low, s_axis_tready_o drops, so no byte is lost
// and the waiting result holds. Once the receiver takes it, bytes flow again in
// the same cycle.
// Reset (rst_ni low, asynchronous) returns to hunting with no sync seen, clears
// the output valid and restores sync_byte to 0x55.
// Configuration writes are meant for idle periods only.
module servo_reply_frame_parser_core
  import srfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o,
  // byte stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,    // [7:0] rx_byte
  // result stream out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,    // [7:0] servo_id, [15:8] command_code,
                                                 // [18:16] param_count, [26:19] param_first,
                                                 // [34:27] param_second, [42:35] param_third,
                                                 // [50:43] param_fourth, rest zero
  output logic                m_axis_tuser_o     // [0] status
);

  typedef enum logic [1:0] {
    HUNT  = 2'd0,
    SYNC1 = 2'd1,
    FRAME = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   len_q;
  logic [ByteW-1:0]  sum_q;
  logic [ByteW-1:0]  id_q;
  logic [ByteW-1:0]  cmd_q;
  logic [ByteW-1:0]  params_q [MaxParams];
  logic [ByteW-1:0]  sync_q;

  logic              out_valid_q, out_valid_d;
  logic              out_status_q;
  logic [ByteW-1:0]  out_id_q;
  logic [ByteW-1:0]  out_cmd_q;
  logic [CountW-1:0] out_count_q;
  logic [ByteW-1:0]  out_params_q [4];

  logic              in_fire;
  logic              cfg_write;
  logic [ByteW-1:0]  rx_byte;
  logic              is_sync;
  logic              len_ok;
  logic [PosW-1:0]   check_pos;
  logic              at_check;
  logic              emit;
  logic [PosW-1:0]   param_off;
  logic [ParamIdxW-1:0] param_idx;

  // handshakes
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign pready_o        = 1'b1;
  assign cfg_write       = psel_i && penable_i && pwrite_i;

  // register read
  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == RegSyncByte) begin
      prdata_o = ApbDataW'(sync_q);
    end
  end

  // byte classification
  assign rx_byte   = s_axis_tdata_i;
  assign is_sync   = (rx_byte == sync_q);
  assign len_ok    = (rx_byte >= LenMin) && (rx_byte <= LenMax);
  assign check_pos = PosW'({1'b0, len_q}) + PosW'(HeaderBytes);
  assign at_check  = (pos_q == check_pos);
  assign param_off = pos_q - PosParam0;
  assign param_idx = param_off[ParamIdxW-1:0];
  assign emit      = in_fire && (phase_q == FRAME) && (pos_q >= PosParam0) && at_check;

  // next phase and position
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    if (in_fire) begin
      unique case (phase_q)
        HUNT: begin
          if (is_sync) phase_d = SYNC1;
        end
        SYNC1: begin
          if (is_sync) begin
            phase_d = FRAME;
            pos_d   = PosId;
          end else begin
            phase_d = HUNT;
          end
        end
        FRAME: begin
          if (pos_q == PosLength && !len_ok) begin
            phase_d = HUNT;
            pos_d   = '0;
          end else if (pos_q < PosParam0) begin
            pos_d = pos_q + PosW'(1);
          end else if (pos_q > check_pos || at_check) begin
            phase_d = HUNT;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
        default: begin
          phase_d = HUNT;
          pos_d   = '0;
        end
      endcase
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= HUNT;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      sync_q      <= SyncByteReset;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_write && paddr_i[2] == RegSyncByte) begin
        sync_q <= pwdata_i[ByteW-1:0];
      end
    end
  end

  // frame capture and running sum
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (phase_q == SYNC1 && is_sync) begin
        sum_q <= '0;
        for (int i = 0; i < MaxParams; i++) begin
          params_q[i] <= '0;
        end
      end else if (phase_q == FRAME) begin
        if (pos_q == PosId) begin
          id_q  <= rx_byte;
          sum_q <= sum_q + rx_byte;
        end else if (pos_q == PosLength) begin
          len_q <= rx_byte[LenW-1:0];
          sum_q <= sum_q + rx_byte;
        end else if (pos_q == PosCommand) begin
          cmd_q <= rx_byte;
          sum_q <= sum_q + rx_byte;
        end else if (pos_q < check_pos) begin
          if (param_off < PosW'(MaxParams)) begin
            params_q[param_idx] <= rx_byte;
          end
          sum_q <= sum_q + rx_byte;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= (~sum_q == rx_byte) ? StatusOk : StatusBadSum;
      out_id_q     <= id_q;
      out_cmd_q    <= cmd_q;
      out_count_q  <= CountW'(len_q - LenW'(MinLength));
      for (int i = 0; i < 4; i++) begin
        out_params_q[i] <= (i < MaxParams) ? params_q[i % MaxParams] : '0;
      end
    end
  end

  // output packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OutDataW'({out_params_q[3], out_params_q[2], out_params_q[1],
                                      out_params_q[0], out_count_q, out_cmd_q, out_id_q});

  // a result only follows an accepted byte inside a frame
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && phase_q == FRAME))
    else $error("result without a frame byte");

  // a bad length byte returns to hunting
  a_bad_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == FRAME && pos_q == PosLength && !len_ok) |=> (phase_q == HUNT))
    else $error("bad length not dropped");

  // count never exceeds the parameter capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_count_q <= CountW'(MaxParams)))
    else $error("parameter count out of range");

  // an absent fourth parameter reads as zero
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_count_q < CountW'(4)) |-> (out_params_q[3] == '0))
    else $error("absent parameter not zero");

  // while a result waits unread, no byte is taken
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !in_fire)
    else $error("byte accepted while result blocked");

endmodule
